// ----- rtl/rpr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_pkg: shared types and constants of the rotary position rotator
// Payload structs, widths, the CORDIC arctangent table and the gain constant.
// ----------------------------------------------------------------------------
package rpr_pkg;

  localparam int PAIRS          = 64;
  localparam int DATA_BITS      = 16;
  localparam int CORDIC_STAGES  = 16;

  localparam int PAIR_IDX_BITS  = 6;
  localparam int POS_BITS       = 16;
  localparam int FREQ_BITS      = 32;
  localparam int ADDR_BITS      = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  // scaled input word, datapath word with headroom, phase residual word
  localparam int W_BITS         = DATA_BITS + 16;
  localparam int CW             = W_BITS + 2;
  localparam int ZW             = FREQ_BITS + 1;

  localparam int QUEUE_DEPTH    = 4;

  localparam int GAIN_BITS      = 31;
  localparam logic signed [GAIN_BITS-1:0] GAIN_COMP = 31'sh26DD3B6A;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_ROTATE = 1'b1
  } func_e;

  typedef struct packed {
    func_e                         func;
    logic [PAIR_IDX_BITS-1:0]      pair_index;
    logic [POS_BITS-1:0]           position;
    logic [FREQ_BITS-1:0]          freq_word;
    logic signed [DATA_BITS-1:0]   x_in;
    logic signed [DATA_BITS-1:0]   y_in;
  } rpr_in_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0]   x_out;
    logic signed [DATA_BITS-1:0]   y_out;
    logic                          saturated;
  } rpr_out_t;

  typedef struct packed {
    logic [FREQ_BITS-1:0]          phase;
    logic signed [W_BITS-1:0]      wx;
    logic signed [W_BITS-1:0]      wy;
  } rpr_work_t;

  typedef struct packed {
    logic can_push;
    logic has_data;
  } rpr_qstat_t;

  // atan(2^-i) / 2pi in 0.32 turns
  function automatic logic [FREQ_BITS-1:0] atan_turn(input logic [4:0] i);
    logic [FREQ_BITS-1:0] a;
    unique case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/rpr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_ram: generic single-port RAM
// One read or write per cycle, registered read data held while not reading.
// ----------------------------------------------------------------------------
module rpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rpr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_front: input side of the rotator
// Accepts transactions, writes table loads, looks up the frequency of a
// rotate, forms the phase and the gain-scaled pair and pushes them on.
// ----------------------------------------------------------------------------
module rpr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rpr_pkg::rpr_in_t   in_data_i,
  output logic               push_o,
  output rpr_pkg::rpr_work_t push_data_o,
  input  logic               push_ok_i
);

  localparam int PW = rpr_pkg::DATA_BITS + rpr_pkg::GAIN_BITS;
  localparam logic signed [PW-1:0] ROUND = PW'(32'sd8192);

  logic                                  accept;
  logic                                  idx_ok;
  logic                                  ram_we;
  logic                                  ram_re;
  logic [rpr_pkg::FREQ_BITS-1:0]         ram_rdata;
  logic [rpr_pkg::FREQ_BITS-1:0]         freq;
  logic signed [PW-1:0]                  px;
  logic signed [PW-1:0]                  py;

  logic                                  s1_valid_q;
  logic                                  s1_hit_q;
  logic [rpr_pkg::POS_BITS-1:0]          s1_pos_q;
  logic signed [rpr_pkg::DATA_BITS-1:0]  s1_x_q;
  logic signed [rpr_pkg::DATA_BITS-1:0]  s1_y_q;

  assign in_stall_o = s1_valid_q && !push_ok_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_ok     = int'(in_data_i.pair_index) < rpr_pkg::PAIRS;
  assign ram_we     = accept && (in_data_i.func == rpr_pkg::FUNC_LOAD) && idx_ok;
  assign ram_re     = accept && (in_data_i.func == rpr_pkg::FUNC_ROTATE);

  rpr_ram #(
    .WIDTH (rpr_pkg::FREQ_BITS),
    .DEPTH (rpr_pkg::PAIRS)
  ) u_freq_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (rpr_pkg::ADDR_BITS'(in_data_i.pair_index)),
    .wdata_i (in_data_i.freq_word),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= ram_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_hit_q <= idx_ok;
      s1_pos_q <= in_data_i.position;
      s1_x_q   <= in_data_i.x_in;
      s1_y_q   <= in_data_i.y_in;
    end
  end

  assign freq = s1_hit_q ? ram_rdata : '0;
  assign px   = PW'(s1_x_q) * PW'(rpr_pkg::GAIN_COMP) + ROUND;
  assign py   = PW'(s1_y_q) * PW'(rpr_pkg::GAIN_COMP) + ROUND;

  assign push_o            = s1_valid_q;
  assign push_data_o.phase = rpr_pkg::FREQ_BITS'(s1_pos_q) * freq;
  assign push_data_o.wx    = rpr_pkg::W_BITS'(px >>> 14);
  assign push_data_o.wy    = rpr_pkg::W_BITS'(py >>> 14);

endmodule

// ----- rtl/rpr_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_queue: short FIFO between the front and the CORDIC back end
// Takes a push in the same cycle as a pop even when full.
// ----------------------------------------------------------------------------
module rpr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rpr_pkg::rpr_work_t  push_data_i,
  input  logic                pop_i,
  output rpr_pkg::rpr_work_t  head_o,
  output rpr_pkg::rpr_qstat_t stat_o
);

  localparam int PTR_BITS = (rpr_pkg::QUEUE_DEPTH > 1) ? $clog2(rpr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(rpr_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(rpr_pkg::QUEUE_DEPTH);
  localparam logic [PTR_BITS-1:0] LAST_C  = PTR_BITS'(rpr_pkg::QUEUE_DEPTH - 1);

  rpr_pkg::rpr_work_t    mem_q [rpr_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign stat_o.has_data = (count_q != '0);
  assign stat_o.can_push = (count_q != DEPTH_C) || pop_i;
  assign do_push         = push_i && stat_o.can_push;
  assign do_pop          = pop_i && stat_o.has_data;
  assign head_o          = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue push lost");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
    else $error("queue pointers disagree while empty");

endmodule

// ----- rtl/rpr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpr_back: pipelined CORDIC back end
// Quarter-turn prerotation, one CORDIC stage per register, then rounding
// and saturation into the output register. The whole pipe advances together.
// ----------------------------------------------------------------------------
module rpr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpr_pkg::rpr_work_t  head_i,
  input  rpr_pkg::rpr_qstat_t stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rpr_pkg::rpr_out_t   out_data_o
);

  localparam int N   = rpr_pkg::CORDIC_STAGES;
  localparam int CW  = rpr_pkg::CW;
  localparam int ZW  = rpr_pkg::ZW;
  localparam int FB  = rpr_pkg::FREQ_BITS;
  localparam int RW  = CW - 16;
  localparam logic signed [CW-1:0] ROUND = CW'(32'sd32768);
  localparam logic signed [RW-1:0] HI    = RW'((2 ** (rpr_pkg::DATA_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] LO    = -HI - RW'(1);

  logic                  en;
  logic [N:0]            v_q;
  logic signed [CW-1:0]  x_q [N+1];
  logic signed [CW-1:0]  y_q [N+1];
  logic signed [ZW-1:0]  z_q [N+1];

  logic [FB-1:0]         qsum;
  logic [1:0]            quad;
  logic [FB-1:0]         resid;
  logic signed [CW-1:0]  wx;
  logic signed [CW-1:0]  wy;
  logic signed [CW-1:0]  x0;
  logic signed [CW-1:0]  y0;

  logic signed [RW-1:0]  rx;
  logic signed [RW-1:0]  ry;
  logic                  clip_x;
  logic                  clip_y;
  logic                  out_valid_q;
  rpr_pkg::rpr_out_t     out_q;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && stat_i.has_data;

  assign qsum  = head_i.phase + FB'(32'h2000_0000);
  assign quad  = qsum[FB-1:FB-2];
  assign resid = head_i.phase - {quad, {(FB-2){1'b0}}};
  assign wx    = CW'(head_i.wx);
  assign wy    = CW'(head_i.wy);

  always_comb begin
    unique case (quad)
      2'd1: begin
        x0 = -wy;
        y0 = wx;
      end
      2'd2: begin
        x0 = -wx;
        y0 = -wy;
      end
      2'd3: begin
        x0 = wy;
        y0 = -wx;
      end
      default: begin
        x0 = wx;
        y0 = wy;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N-1:0], stat_i.has_data};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q[0] <= x0;
      y_q[0] <= y0;
      z_q[0] <= $signed({resid[FB-1], resid});
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] a;

    assign dx = y_q[k-1] >>> (k - 1);
    assign dy = x_q[k-1] >>> (k - 1);
    assign a  = $signed({1'b0, rpr_pkg::atan_turn(5'(k - 1))});

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!z_q[k-1][ZW-1]) begin
          x_q[k] <= x_q[k-1] - dx;
          y_q[k] <= y_q[k-1] + dy;
          z_q[k] <= z_q[k-1] - a;
        end else begin
          x_q[k] <= x_q[k-1] + dx;
          y_q[k] <= y_q[k-1] - dy;
          z_q[k] <= z_q[k-1] + a;
        end
      end
    end
  end

  assign rx     = RW'((x_q[N] + ROUND) >>> 16);
  assign ry     = RW'((y_q[N] + ROUND) >>> 16);
  assign clip_x = (rx > HI) || (rx < LO);
  assign clip_y = (ry > HI) || (ry < LO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.x_out     <= (rx > HI) ? rpr_pkg::DATA_BITS'(HI) :
                         (rx < LO) ? rpr_pkg::DATA_BITS'(LO) : rpr_pkg::DATA_BITS'(rx);
      out_q.y_out     <= (ry > HI) ? rpr_pkg::DATA_BITS'(HI) :
                         (ry < LO) ? rpr_pkg::DATA_BITS'(LO) : rpr_pkg::DATA_BITS'(ry);
      out_q.saturated <= clip_x || clip_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/rotary_position_rotator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_position_rotator: rotary position embedding of one element pair
// Input channel in_valid_i / in_stall_o / in_data_i carries load and rotate
// transactions; a load writes one frequency table entry and gives no result,
// a rotate gives one result on out_valid_o / out_stall_i / out_data_o.
// A transaction moves at a rising edge with valid high and stall low.
// A rotate passes from acceptance to out_valid_o through the table read
// register (with the phase and gain multiply behind it), the queue, the
// quarter-turn stage, one register per CORDIC stage and the output stage.
// Throughput: one transaction per cycle while in_stall_o is low, loads and rotates
// alike, set by the single-port frequency RAM and the fully pipelined CORDIC.
// A load may be followed directly by a rotate of the same entry.
// While the receiver stalls, the CORDIC pipe holds and the four-entry queue
// fills; input stall rises only once the queue and the lookup stage are full.
// Reset clears all valid state and queue pointers; the table keeps no reset
// value and must be loaded before an entry is used.
// ----------------------------------------------------------------------------
module rotary_position_rotator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rpr_pkg::rpr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rpr_pkg::rpr_out_t out_data_o
);

  logic                push;
  rpr_pkg::rpr_work_t  push_data;
  rpr_pkg::rpr_work_t  head;
  rpr_pkg::rpr_qstat_t qstat;
  logic                pop;

  rpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .push_ok_i   (qstat.can_push)
  );

  rpr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (qstat)
  );

  rpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rotary_position_rotator
// Loads frequency table entries and rotates element pairs through the
// valid/stall channels with random gaps and output stalls. Each rotate
// transaction is predicted by a bit-exact CORDIC model kept in this bench,
// and every result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_ITEMS = 1290;
  localparam longint GAIN_Q30 = 64'h26DD3B6A;
  localparam bit [31:0] ATAN_TURNS [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  rpr_pkg::rpr_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  rpr_pkg::rpr_out_t out_data_o;

  logic [31:0]       freq_model [rpr_pkg::PAIRS];
  rpr_pkg::rpr_out_t pending_results [$];
  int                err_count = 0;
  bit                no_gaps = 1'b0;

  rotary_position_rotator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [15:0] clip16(input longint v, inout bit clipped);
    if (v > 32767) begin
      clipped = 1'b1;
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      clipped = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic rpr_pkg::rpr_out_t rotate_pair(input logic [31:0] freq,
                                                    input logic [15:0] pos,
                                                    input logic signed [15:0] xv,
                                                    input logic signed [15:0] yv);
    logic [47:0]       prod;
    logic [31:0]       phase;
    logic [31:0]       qsum;
    logic [31:0]       resid;
    logic [1:0]        quad;
    longint            x, y, z, t, dx, dy;
    bit                clipped;
    rpr_pkg::rpr_out_t r;
    prod  = 48'(pos) * 48'(freq);
    phase = prod[31:0];
    qsum  = phase + 32'h20000000;
    quad  = qsum[31:30];
    resid = phase - {quad, 30'b0};
    z     = longint'($signed(resid));
    x     = (longint'(xv) * GAIN_Q30 + 8192) >>> 14;
    y     = (longint'(yv) * GAIN_Q30 + 8192) >>> 14;
    case (quad)
      2'd1: begin
        t = x; x = -y; y = t;
      end
      2'd2: begin
        x = -x; y = -y;
      end
      2'd3: begin
        t = x; x = y; y = -t;
      end
      default: ;
    endcase
    for (int i = 0; i < rpr_pkg::CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
      end
    end
    clipped     = 1'b0;
    r.x_out     = clip16((x + 32768) >>> 16, clipped);
    r.y_out     = clip16((y + 32768) >>> 16, clipped);
    r.saturated = clipped;
    return r;
  endfunction

  function automatic rpr_pkg::rpr_in_t load_item(input int idx, input logic [31:0] freq);
    rpr_pkg::rpr_in_t it;
    it.func       = rpr_pkg::FUNC_LOAD;
    it.pair_index = idx[5:0];
    it.position   = 16'($urandom);
    it.freq_word  = freq;
    it.x_in       = 16'($urandom);
    it.y_in       = 16'($urandom);
    return it;
  endfunction

  function automatic rpr_pkg::rpr_in_t rotate_item(input int idx, input logic [15:0] pos,
                                                   input logic signed [15:0] xv,
                                                   input logic signed [15:0] yv);
    rpr_pkg::rpr_in_t it;
    it.func       = rpr_pkg::FUNC_ROTATE;
    it.pair_index = idx[5:0];
    it.position   = pos;
    it.freq_word  = $urandom;
    it.x_in       = xv;
    it.y_in       = yv;
    return it;
  endfunction

  // called at a rising edge; returns at the edge where the transaction moved
  task automatic send_item(input rpr_pkg::rpr_in_t item);
    int gap;
    gap = no_gaps ? 0 : rand_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (item.func == rpr_pkg::FUNC_LOAD) begin
      freq_model[item.pair_index] = item.freq_word;
    end else begin
      pending_results.push_back(rotate_pair(freq_model[item.pair_index], item.position,
                                            item.x_in, item.y_in));
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_table_load();
    send_item(load_item(0, 32'h00000000));
    send_item(load_item(63, 32'hFFFFFFFF));
    send_item(load_item(1, 32'h40000000));
    send_item(load_item(2, 32'h20000000));
    send_item(load_item(3, 32'h80000000));
    send_item(load_item(4, 32'hC0000000));
    send_item(load_item(5, 32'h00000001));
  endtask

  task automatic test_rotate_corners();
    send_item(rotate_item(0, 16'd0, 16'sh7FFF, 16'sh8000));
    send_item(rotate_item(0, 16'hFFFF, 16'sh8000, 16'sh7FFF));
    send_item(rotate_item(63, 16'hFFFF, 16'sd12345, -16'sd4321));
    send_item(rotate_item(1, 16'd1, 16'sd4096, 16'sd0));
    send_item(rotate_item(3, 16'd1, 16'sh8000, 16'sh8000));
    send_item(rotate_item(4, 16'd1, 16'sh7FFF, 16'sd0));
    send_item(rotate_item(2, 16'd1, 16'sh7FFF, 16'sh7FFF));
    send_item(rotate_item(5, 16'hFFFF, 16'sd0, 16'sd0));
    send_item(rotate_item(2, 16'd3, 16'sh8000, 16'sh7FFF));
  endtask

  // a rotate right behind the load of its own entry
  task automatic test_load_then_rotate();
    no_gaps = 1'b1;
    send_item(load_item(10, 32'h12345678));
    send_item(rotate_item(10, 16'd1000, -16'sd20000, 16'sd15000));
    send_item(load_item(10, 32'h00ABCDEF));
    send_item(rotate_item(10, 16'd777, 16'sd32000, -16'sd32000));
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [31:0]        freq;
    logic [15:0]        pos;
    logic signed [15:0] xv, yv;
    logic signed [15:0] corners [4];
    corners = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1};
    for (int i = 0; i < rpr_pkg::PAIRS; i++) begin
      freq = $urandom;
      if ($urandom_range(0, 1)) freq = freq >> $urandom_range(0, 31);
      send_item(load_item(i, freq));
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 4) == 0) begin
        freq = $urandom;
        if ($urandom_range(0, 1)) freq = freq >> $urandom_range(0, 31);
        send_item(load_item($urandom_range(0, rpr_pkg::PAIRS - 1), freq));
      end else begin
        pos = ($urandom_range(0, 9) < 7) ? 16'($urandom) : 16'($urandom_range(0, 255));
        xv  = ($urandom_range(0, 6) == 0) ? corners[$urandom_range(0, 3)] : 16'($urandom);
        yv  = ($urandom_range(0, 6) == 0) ? corners[$urandom_range(0, 3)] : 16'($urandom);
        send_item(rotate_item($urandom_range(0, rpr_pkg::PAIRS - 1), pos, xv, yv));
      end
    end
    no_gaps = 1'b0;
  endtask

  // output stall: alternating stall and go runs, some go runs long
  initial begin
    int run;
    bit hold;
    out_stall_i <= 1'b0;
    run  = 0;
    hold = 1'b0;
    forever begin
      @(posedge clk_i);
      if (run == 0) begin
        hold = !hold;
        if (hold) run = rand_gap();
        else run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 8);
      end
      out_stall_i <= hold && (run != 0);
      if (run != 0) run--;
    end
  end

  always @(posedge clk_i) begin
    rpr_pkg::rpr_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: x_out %0d y_out %0d saturated %0b",
               out_data_o.x_out, out_data_o.y_out, out_data_o.saturated);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.x_out !== want.x_out) begin
          $error("x_out: expected %0d, actual %0d", want.x_out, out_data_o.x_out);
          err_count++;
        end
        if (out_data_o.y_out !== want.y_out) begin
          $error("y_out: expected %0d, actual %0d", want.y_out, out_data_o.y_out);
          err_count++;
        end
        if (out_data_o.saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated,
                 out_data_o.saturated);
          err_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_table_load();
    test_rotate_corners();
    test_load_then_rotate();
    wait_drained();
    test_random_traffic();
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
